FILE: src/pbnp_pkg.sv
package pbnp_pkg;

	// widths of the fields
	localparam int COLOR_W      = 16;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int WORD_W       = 32;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int POS_W        = 3;

	// palette geometry
	localparam int CELL_COUNT   = 16;
	localparam int PAL_ENTRIES  = 16;
	localparam int PIX_PER_WORD = 8;

	// stream widths
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 48;
	localparam int M_PAYLOAD_W  = STATUS_W + IDX_W + CNT_W + WORD_W;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_LEARN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INDEX = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// learn status codes
	localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ADDED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	// result kinds
	localparam logic KIND_LEARN = 1'b0;
	localparam logic KIND_WORD  = 1'b1;

	// request travelling down the cell chain
	typedef struct packed {
		logic                valid;
		logic [FUNC_W-1:0]   func;
		logic [COLOR_W-1:0]  color;
		logic                hit;
		logic                added;
		logic [IDX_W-1:0]    idx;
	} item_t;

endpackage

FILE: src/pbnp_cell.sv
module pbnp_cell
	import pbnp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [IDX_W-1:0] cell_id,
	input  item_t            item_in,
	output item_t            item_out
);

	logic [COLOR_W-1:0] entry_q;
	logic               filled_q;
	item_t              item_q;
	item_t              next_item;
	logic               match;
	logic               can_fill;
	logic               take;

	// compare with this entry and update the travelling request
	always_comb begin
		next_item = item_in;
		take      = 1'b0;
		match     = (entry_q == item_in.color);
		can_fill  = ({1'b0, cell_id} < CNT_W'(PAL_ENTRIES));
		case (item_in.func)
			FUNC_LEARN: begin
				if (!item_in.hit) begin
					if (filled_q && match) begin
						next_item.hit = 1'b1;
						next_item.idx = cell_id;
					end else if (!filled_q && !item_in.added && can_fill) begin
						take            = 1'b1;
						next_item.added = 1'b1;
						next_item.idx   = cell_id;
					end
				end
			end
			FUNC_INDEX: begin
				if (!item_in.hit && match) begin
					next_item.hit = 1'b1;
					next_item.idx = cell_id;
				end
			end
			default: ;
		endcase
	end

	// palette entry held by this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			filled_q <= 1'b0;
		end else if (advance && item_in.valid) begin
			if (item_in.func == FUNC_CLEAR) begin
				entry_q  <= '0;
				filled_q <= 1'b0;
			end else if (take) begin
				entry_q  <= item_in.color;
				filled_q <= 1'b1;
			end
		end
	end

	// hand the request to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (advance) begin
			item_q <= next_item;
		end
	end

	assign item_out = item_q;

endmodule

FILE: src/pbnp_tail.sv
module pbnp_tail
	import pbnp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                item_in,
	input  logic                 m_tready,
	output logic                 advance,
	output logic                 m_tvalid,
	output logic                 m_tuser,
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [CNT_W-1:0]    fill_q;
	logic [WORD_W-1:0]   acc_q;
	logic [POS_W-1:0]    pos_q;
	logic                out_valid_q;
	logic                out_kind_q;
	logic [M_PAYLOAD_W-1:0] out_data_q;

	logic                need_out;
	logic                take;
	logic [IDX_W-1:0]    found;
	logic [WORD_W-1:0]   acc_next;
	logic [CNT_W-1:0]    fill_next;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    rep_idx;
	logic                last_pos;

	// the tail request needs the output register for a learn report or a full word
	always_comb begin
		last_pos = (pos_q == POS_W'(PIX_PER_WORD - 1));
		need_out = item_in.valid &&
			((item_in.func == FUNC_LEARN) || ((item_in.func == FUNC_INDEX) && last_pos));
		advance  = !need_out || !out_valid_q || m_tready;
		take     = item_in.valid && advance;
	end

	// learn report and packing arithmetic
	always_comb begin
		found     = item_in.hit ? item_in.idx : '0;
		acc_next  = acc_q | ({{(WORD_W-IDX_W){1'b0}}, found} << {~pos_q, 2'b00});
		fill_next = item_in.added ? fill_q + CNT_W'(1) : fill_q;
		if (item_in.hit) begin
			status  = STATUS_PRESENT;
			rep_idx = item_in.idx;
		end else if (item_in.added) begin
			status  = STATUS_ADDED;
			rep_idx = item_in.idx;
		end else begin
			status  = STATUS_OVERFLOW;
			rep_idx = '0;
		end
	end

	// fill count and packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
		end else if (take) begin
			case (item_in.func)
				FUNC_LEARN: fill_q <= fill_next;
				FUNC_INDEX: begin
					pos_q <= pos_q + POS_W'(1);
					acc_q <= last_pos ? '0 : acc_next;
				end
				FUNC_CLEAR: begin
					fill_q <= '0;
					acc_q  <= '0;
					pos_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_LEARN;
			out_data_q  <= '0;
		end else if (take && need_out) begin
			out_valid_q <= 1'b1;
			if (item_in.func == FUNC_LEARN) begin
				out_kind_q <= KIND_LEARN;
				out_data_q <= {{WORD_W{1'b0}}, fill_next, rep_idx, status};
			end else begin
				out_kind_q <= KIND_WORD;
				out_data_q <= {acc_next, fill_q, {IDX_W{1'b0}}, STATUS_PRESENT};
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{(M_TDATA_W-M_PAYLOAD_W){1'b0}}, out_data_q};

endmodule

FILE: src/palette_builder_and_nibble_packer.sv
// channel | fields, lowest bit first                              | handshake
// s_*     | tuser: func[1:0]; tdata: color[15:0]                  | tvalid/tready
// m_*     | tuser: kind; tdata: status[1:0], entry_index[5:2],    | tvalid/tready
//         |   entry_count[10:6], packed_word[42:11], zero fill    |
// one request enters per cycle unless stalled and walks a chain of 16 palette cells,
// one cell a cycle: the first cell registers it at the accepting edge, each further
// cell registers it in turn and the output register holds the result last
// reset clears the palette, fill count, packer and output register at once
// the chain stalls only when the request at its tail needs the output register while
// a result is still held there; requests that give no result drain regardless
module palette_builder_and_nibble_packer
	import pbnp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [FUNC_W-1:0]    s_tuser,  // func[1:0]
	input  logic [S_TDATA_W-1:0] s_tdata,  // color[15:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_tuser,  // kind
	output logic [M_TDATA_W-1:0] m_tdata   // status, entry_index, entry_count, packed_word
);

	item_t chain [0:CELL_COUNT];
	logic  advance;

	// request entering the first cell
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = s_tvalid;
		chain[0].func  = s_tuser;
		chain[0].color = s_tdata[COLOR_W-1:0];
	end

	assign s_tready = advance;

	// row of palette cells
	for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
		pbnp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.cell_id  (IDX_W'(k)),
			.item_in  (chain[k]),
			.item_out (chain[k+1])
		);
	end

	// fill count, packer and output register
	pbnp_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (chain[CELL_COUNT]),
		.m_tready (m_tready),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: src/pbnp_checker.sv
module pbnp_checker
	import pbnp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [FUNC_W-1:0]    s_tuser,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic                 m_tuser,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// learn reports never name a count above the palette size or a bad status, and carry a zero word
	a_learn_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_LEARN) |->
			(m_tdata[10:6] <= CNT_W'(PAL_ENTRIES)) && (m_tdata[1:0] != 2'd3)
			&& (m_tdata[42:11] == '0))
		else $error("malformed learn report");

	// a packed word carries zero status and index
	a_word_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_WORD) |-> (m_tdata[5:0] == '0))
		else $error("malformed packed word");

endmodule

bind palette_builder_and_nibble_packer pbnp_checker u_pbnp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);

FILE: dv/tb_palette_builder_and_nibble_packer.sv
module tb_palette_builder_and_nibble_packer;
	import pbnp_pkg::*;

	// func code that the block must ignore
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	// idling phases
	localparam int MODE_FLAT     = 0;
	localparam int MODE_SRC_IDLE = 1;
	localparam int MODE_SNK_STALL = 2;
	localparam int MODE_BOTH     = 3;

	localparam int RANDOM_REQUESTS = 1350;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [COLOR_W-1:0] color;
		int                 mode;
		bit                 drain;
	} pixel_req_t;

	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    entry_index;
		logic [CNT_W-1:0]    entry_count;
		logic [WORD_W-1:0]   packed_word;
	} pal_report_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [FUNC_W-1:0]    s_tuser = '0;   // func[1:0]
	logic [S_TDATA_W-1:0] s_tdata = '0;   // color[15:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 m_tuser;        // kind
	logic [M_TDATA_W-1:0] m_tdata;        // status, entry_index, entry_count, packed_word

	// shadow copy of the palette and packer
	logic [COLOR_W-1:0] shadow_pal [CELL_COUNT];
	logic [CNT_W-1:0]   shadow_fill;
	logic [WORD_W-1:0]  shadow_acc;
	logic [POS_W-1:0]   shadow_pos;

	pixel_req_t  pixel_q [$];
	pal_report_t report_q [$];
	bit          in_taken = 1'b0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          cur_mode = MODE_FLAT;
	bit          cur_drain = 1'b0;

	palette_builder_and_nibble_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// work out the report a request causes, if any
	task automatic predict_palette(input logic [FUNC_W-1:0] func, input logic [COLOR_W-1:0] color);
		pal_report_t rep;
		bit          hit;
		int          slot;
		int          shift;
		rep = '0;
		hit = 1'b0;
		slot = 0;
		case (func)
			FUNC_LEARN: begin
				// only filled entries count on learn
				for (int i = 0; i < CELL_COUNT; i++) begin
					if (!hit && i < shadow_fill && shadow_pal[i] == color) begin
						hit = 1'b1;
						slot = i;
					end
				end
				rep.kind = KIND_LEARN;
				if (hit) begin
					rep.status = STATUS_PRESENT;
					rep.entry_index = slot[IDX_W-1:0];
				end else if (shadow_fill >= PAL_ENTRIES) begin
					rep.status = STATUS_OVERFLOW;
				end else begin
					shadow_pal[shadow_fill[IDX_W-1:0]] = color;
					rep.status = STATUS_ADDED;
					rep.entry_index = shadow_fill[IDX_W-1:0];
					shadow_fill = shadow_fill + 1'b1;
				end
				rep.entry_count = shadow_fill;
				report_q.push_back(rep);
			end
			FUNC_INDEX: begin
				// all cells searched, unused ones hold zero
				for (int i = 0; i < CELL_COUNT; i++) begin
					if (!hit && shadow_pal[i] == color) begin
						hit = 1'b1;
						slot = i;
					end
				end
				shift = (PIX_PER_WORD - 1 - shadow_pos) * IDX_W;
				shadow_acc = shadow_acc | (WORD_W'(slot) << shift);
				shadow_pos = shadow_pos + 1'b1;
				if (shadow_pos == '0) begin
					rep.kind = KIND_WORD;
					rep.entry_count = shadow_fill;
					rep.packed_word = shadow_acc;
					shadow_acc = '0;
					report_q.push_back(rep);
				end
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++) shadow_pal[i] = '0;
				shadow_fill = '0;
				shadow_acc = '0;
				shadow_pos = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic push_req(input logic [FUNC_W-1:0] func, input logic [COLOR_W-1:0] color);
		pixel_req_t r;
		r.func = func;
		r.color = color;
		r.mode = cur_mode;
		r.drain = cur_drain;
		cur_drain = 1'b0;
		pixel_q.push_back(r);
	endtask

	// request driver, falling edge
	always @(negedge clk) begin
		pixel_req_t nxt;
		int         gap_pct;
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
		if (arst_n && (!s_tvalid || in_taken)) begin
			gap_pct = 0;
			if (pixel_q.size() != 0) begin
				nxt = pixel_q[0];
				if (nxt.mode == MODE_SRC_IDLE) gap_pct = 66;
				else if (nxt.mode == MODE_BOTH) gap_pct = 18;
			end
			if (pixel_q.size() == 0 || (nxt.drain && report_q.size() != 0) ||
			    $urandom_range(0, 99) < gap_pct) begin
				s_tvalid <= 1'b0;
				s_tuser <= FUNC_W'($urandom);
				s_tdata <= S_TDATA_W'($urandom);
			end else begin
				void'(pixel_q.pop_front());
				s_tvalid <= 1'b1;
				s_tuser <= nxt.func;
				s_tdata <= nxt.color;
				if (nxt.mode == MODE_SNK_STALL) stall_pct = 66;
				else if (nxt.mode == MODE_BOTH) stall_pct = 18;
				else stall_pct = 0;
			end
		end
	end

	// monitor and prediction, rising edge
	always @(posedge clk) begin
		pal_report_t got;
		pal_report_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			// results first, a request cannot come back in its own cycle
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.status = m_tdata[1:0];
				got.entry_index = m_tdata[5:2];
				got.entry_count = m_tdata[10:6];
				got.packed_word = m_tdata[42:11];
				if (report_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d status %0d index %0d count %0d word %08h",
							got.kind, got.status, got.entry_index, got.entry_count,
							got.packed_word);
				end else begin
					want = report_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind %0d status %0d index %0d count %0d word %08h,",
								" got kind %0d status %0d index %0d count %0d word %08h"},
								want.kind, want.status, want.entry_index, want.entry_count,
								want.packed_word, got.kind, got.status, got.entry_index,
								got.entry_count, got.packed_word);
					end
				end
			end
			if (s_tvalid && s_tready) predict_palette(s_tuser, s_tdata);
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [COLOR_W-1:0] pool [20];
		int                 counted;
		int                 seg;
		int                 pool_n;
		int                 n_learn;
		int                 n_index;
		int                 pick;

		for (int i = 0; i < CELL_COUNT; i++) shadow_pal[i] = '0;
		shadow_fill = '0;
		shadow_acc = '0;
		shadow_pos = '0;

		// directed: empty lookup, repeat, ignored func, fill, overflow, partial word dropped
		push_req(FUNC_INDEX, 16'h0000);
		push_req(FUNC_LEARN, 16'hFFFF);
		push_req(FUNC_LEARN, 16'hFFFF);
		push_req(FUNC_LEARN, 16'h0000);
		push_req(FUNC_NONE, 16'hAAAA);
		for (int k = 0; k < 14; k++) push_req(FUNC_LEARN, 16'h0001 << k);
		push_req(FUNC_LEARN, 16'h5555);
		push_req(FUNC_LEARN, 16'h0000);
		push_req(FUNC_INDEX, 16'hFFFF);
		push_req(FUNC_INDEX, 16'h0000);
		push_req(FUNC_INDEX, 16'h2000);
		push_req(FUNC_INDEX, 16'h4000);
		push_req(FUNC_CLEAR, 16'hFFFF);

		// random segments: clear in most, learn from a small pool, index mostly in whole words
		counted = 0;
		seg = 0;
		while (counted < RANDOM_REQUESTS) begin
			seg++;
			cur_mode = (seg / 3) % 4;
			if (seg % 12 == 0) cur_drain = 1'b1;
			pool_n = $urandom_range(1, 20);
			for (int i = 0; i < pool_n; i++) begin
				case ($urandom_range(0, 7))
					0: pool[i] = 16'h0000;
					1: pool[i] = 16'hFFFF;
					default: pool[i] = COLOR_W'($urandom);
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				push_req(FUNC_CLEAR, COLOR_W'($urandom));
				counted++;
			end
			n_learn = $urandom_range(1, 20);
			for (int i = 0; i < n_learn; i++) begin
				push_req(FUNC_LEARN, pool[$urandom_range(0, pool_n - 1)]);
				counted++;
			end
			n_index = 8 * $urandom_range(1, 6);
			if ($urandom_range(0, 4) == 0) n_index += $urandom_range(1, 7);
			for (int i = 0; i < n_index; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 8) push_req(FUNC_INDEX, pool[$urandom_range(0, pool_n - 1)]);
				else if (pick == 8) push_req(FUNC_INDEX, COLOR_W'($urandom));
				else push_req(FUNC_INDEX, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
				counted++;
				// noise within the word
				if ($urandom_range(0, 39) == 0) push_req(FUNC_NONE, COLOR_W'($urandom));
				if ($urandom_range(0, 149) == 0) begin
					push_req(FUNC_CLEAR, COLOR_W'($urandom));
					counted++;
				end
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_q.size() != 0 || s_tvalid) @(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && report_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
src/pbnp_pkg.sv
src/pbnp_cell.sv
src/pbnp_tail.sv
src/palette_builder_and_nibble_packer.sv
src/pbnp_checker.sv
dv/tb_palette_builder_and_nibble_packer.sv
